[rtl/core/reduction_tree_message_counter_top_assert.svh]
// assertion macros for the reduction tree message counter
`ifndef REDUCTION_TREE_MESSAGE_COUNTER_TOP_ASSERT_SVH
`define REDUCTION_TREE_MESSAGE_COUNTER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RTMC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rtmc: same-cycle check failed");

// next-cycle implication, checked out of reset
`define RTMC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rtmc: next-cycle check failed");

`endif

[rtl/core/rtmc_pkg.sv]
// control store, step codes and control word type of the message counter
package rtmc_pkg;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] t_pc;

    // datapath operations
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_LOAD     = 4'd1;
    localparam logic [3:0] OP_DIV_INIT = 4'd2;
    localparam logic [3:0] OP_DIV_STEP = 4'd3;
    localparam logic [3:0] OP_SPLIT    = 4'd4;
    localparam logic [3:0] OP_SIZE     = 4'd5;
    localparam logic [3:0] OP_JCALC    = 4'd6;
    localparam logic [3:0] OP_ADV      = 4'd7;
    localparam logic [3:0] OP_NEXT     = 4'd8;
    localparam logic [3:0] OP_OUT      = 4'd9;
    localparam logic [3:0] OP_SPECIAL  = 4'd10;

    // jump conditions
    localparam logic [2:0] C_NEVER     = 3'd0;
    localparam logic [2:0] C_ALWAYS    = 3'd1;
    localparam logic [2:0] C_NO_REQ    = 3'd2;
    localparam logic [2:0] C_SPECIAL   = 3'd3;
    localparam logic [2:0] C_DIV_MORE  = 3'd4;
    localparam logic [2:0] C_IDX_DONE  = 3'd5;
    localparam logic [2:0] C_RANK_MORE = 3'd6;
    localparam logic [2:0] C_OUT_FREE  = 3'd7;

    // program steps
    localparam t_pc PC_IDLE     = 4'd0;
    localparam t_pc PC_CHECK    = 4'd1;
    localparam t_pc PC_DIV_INIT = 4'd2;
    localparam t_pc PC_DIV      = 4'd3;
    localparam t_pc PC_SPLIT    = 4'd4;
    localparam t_pc PC_SIZE     = 4'd5;
    localparam t_pc PC_WALK     = 4'd6;
    localparam t_pc PC_ADV      = 4'd7;
    localparam t_pc PC_NEXT     = 4'd8;
    localparam t_pc PC_OUT      = 4'd9;
    localparam t_pc PC_OUT_WAIT = 4'd10;
    localparam t_pc PC_SPECIAL  = 4'd11;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] cond;
        t_pc        target;
    } t_ctrl;

    // control store: a true condition jumps to target, else fall through
    function automatic t_ctrl ctrl_rom(input t_pc pc);
        t_ctrl w;
        case (pc)
            PC_IDLE:     w = '{OP_LOAD,     C_NO_REQ,    PC_IDLE};
            PC_CHECK:    w = '{OP_NONE,     C_SPECIAL,   PC_SPECIAL};
            PC_DIV_INIT: w = '{OP_DIV_INIT, C_NEVER,     PC_IDLE};
            PC_DIV:      w = '{OP_DIV_STEP, C_DIV_MORE,  PC_DIV};
            PC_SPLIT:    w = '{OP_SPLIT,    C_NEVER,     PC_IDLE};
            PC_SIZE:     w = '{OP_SIZE,     C_NEVER,     PC_IDLE};
            PC_WALK:     w = '{OP_JCALC,    C_IDX_DONE,  PC_NEXT};
            PC_ADV:      w = '{OP_ADV,      C_ALWAYS,    PC_WALK};
            PC_NEXT:     w = '{OP_NEXT,     C_RANK_MORE, PC_SIZE};
            PC_OUT:      w = '{OP_OUT,      C_OUT_FREE,  PC_IDLE};
            PC_OUT_WAIT: w = '{OP_NONE,     C_ALWAYS,    PC_OUT};
            PC_SPECIAL:  w = '{OP_SPECIAL,  C_ALWAYS,    PC_OUT};
            default:     w = '{OP_NONE,     C_ALWAYS,    PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

[rtl/core/reduction_tree_message_counter_top.sv]
// top level of the reduction tree message counter
// Usage: an element count arrives on the s_axis request channel; the block
// returns the number of messages of a binary-indexed reduction tree on the
// m_axis channel, one result per request. The rank count and the remainder
// placement mode are to be written over the APB port only while the block
// is idle; the block itself does not enforce this.
// Timing: s_axis_tready is high only while the sequencer waits at its idle
// step, so one request is worked on at a time. A request that falls under a
// special case (rank count at most one, or element count at most the rank
// count) goes from the check step through the special step to the output
// step. Otherwise the shift-subtract divider gives one quotient bit per
// cycle, then the walk takes two control steps per message, all run by the
// control store. The next request can be taken in the cycle after the result
// is loaded. Reset: the sequencer returns to idle, the result register
// empties, the rank count becomes 2 and the remainder mode 0.
// Stall: a result waits in the output register until m_axis_tready; the
// sequencer moves between its output and wait steps until the register is free.
`include "reduction_tree_message_counter_top_assert.svh"

module reduction_tree_message_counter_top #(
    parameter int COUNT_WIDTH = 32,
    parameter int RANK_WIDTH  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // fields from bit 0: element_count
    input  logic [((COUNT_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    // result channel
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // fields from bit 0: message_count
    output logic [31:0]                         m_axis_tdata,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int CNT_W = $clog2(COUNT_WIDTH + 1);
    localparam int XW    = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
    localparam int CMPW  = (COUNT_WIDTH > RANK_WIDTH) ? COUNT_WIDTH : RANK_WIDTH;
    localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(COUNT_WIDTH);

    // configuration registers
    logic [RANK_WIDTH-1:0]  r_rank_count;
    logic                   r_mode;

    // sequencer
    rtmc_pkg::t_pc          r_pc;
    rtmc_pkg::t_pc          n_pc;
    rtmc_pkg::t_ctrl        ctrl;
    logic                   cond_true;

    // datapath
    logic [COUNT_WIDTH-1:0] r_n;
    logic [RANK_WIDTH-1:0]  r_rem;
    logic [CNT_W-1:0]       r_cnt;
    logic [RANK_WIDTH-1:0]  r_r;
    logic [COUNT_WIDTH-1:0] r_start;
    logic [COUNT_WIDTH-1:0] r_stop;
    logic [COUNT_WIDTH-1:0] r_idx;
    logic [COUNT_WIDTH-1:0] r_jump;
    logic [COUNT_WIDTH-1:0] r_diff;
    logic [31:0]            r_total;
    logic                   r_out_valid;
    logic [31:0]            r_out_data;

    logic                   in_fire;
    logic                   out_free;
    logic                   cfg_wr;
    logic                   special;
    logic [CMPW-1:0]        n_cmp;
    logic [CMPW-1:0]        m_cmp;
    logic [XW-1:0]          n_dec;
    logic [RANK_WIDTH:0]    div_t;
    logic                   div_ge;
    logic [RANK_WIDTH-1:0]  rank_sel;
    logic                   inc;
    logic [COUNT_WIDTH-1:0] low_bit;

    assign ctrl          = rtmc_pkg::ctrl_rom(r_pc);
    assign s_axis_tready = (r_pc == rtmc_pkg::PC_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // apb access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = paddr[2] ? 32'(r_mode) : 32'(r_rank_count);

    // special cases: too few ranks, or no more elements than ranks
    assign n_cmp   = CMPW'(r_n);
    assign m_cmp   = CMPW'(r_rank_count);
    assign special = (m_cmp <= CMPW'(1)) || (n_cmp <= m_cmp);
    assign n_dec   = XW'(r_n) - XW'(1);

    // shift-subtract divider step
    assign div_t  = {r_rem, r_n[COUNT_WIDTH-1]};
    assign div_ge = (div_t >= {1'b0, r_rank_count});

    // one extra element for this rank, rank zero while splitting
    assign rank_sel = (ctrl.op == rtmc_pkg::OP_SPLIT) ? '0 : r_r;
    assign inc      = r_mode ? ((r_rank_count - RANK_WIDTH'(1) - rank_sel) < r_rem)
                             : (rank_sel < r_rem);

    // subtree size of the current index
    assign low_bit = r_idx & (~r_idx + COUNT_WIDTH'(1));

    // jump condition select
    always_comb begin
        case (ctrl.cond)
            rtmc_pkg::C_NEVER:     cond_true = 1'b0;
            rtmc_pkg::C_ALWAYS:    cond_true = 1'b1;
            rtmc_pkg::C_NO_REQ:    cond_true = !in_fire;
            rtmc_pkg::C_SPECIAL:   cond_true = special;
            rtmc_pkg::C_DIV_MORE:  cond_true = (r_cnt != CNT_W'(1));
            rtmc_pkg::C_IDX_DONE:  cond_true = (r_idx >= r_stop);
            rtmc_pkg::C_RANK_MORE: cond_true = ({1'b0, r_r} + (RANK_WIDTH+1)'(1))
                                               < {1'b0, r_rank_count};
            rtmc_pkg::C_OUT_FREE:  cond_true = out_free;
            default:               cond_true = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        if (cond_true) begin
            n_pc = ctrl.target;
        end else begin
            n_pc = r_pc + rtmc_pkg::t_pc'(1);
        end
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc         <= rtmc_pkg::PC_IDLE;
            r_out_valid  <= 1'b0;
            r_rank_count <= RANK_WIDTH'(2);
            r_mode       <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (ctrl.op == rtmc_pkg::OP_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                if (!paddr[2]) begin
                    r_rank_count <= pwdata[RANK_WIDTH-1:0];
                end else begin
                    r_mode <= pwdata[0];
                end
            end
        end
    end

    // datapath driven by the control word
    always_ff @(posedge i_clk) begin
        case (ctrl.op)
            rtmc_pkg::OP_LOAD: begin
                if (in_fire) begin
                    r_n <= s_axis_tdata[COUNT_WIDTH-1:0];
                end
            end
            rtmc_pkg::OP_DIV_INIT: begin
                r_rem <= '0;
                r_cnt <= CNT_INIT;
            end
            rtmc_pkg::OP_DIV_STEP: begin
                if (div_ge) begin
                    r_rem <= RANK_WIDTH'(div_t - {1'b0, r_rank_count});
                end else begin
                    r_rem <= div_t[RANK_WIDTH-1:0];
                end
                r_n   <= {r_n[COUNT_WIDTH-2:0], div_ge};
                r_cnt <= r_cnt - CNT_W'(1);
            end
            rtmc_pkg::OP_SPLIT: begin
                r_start <= r_n + COUNT_WIDTH'(inc);
                r_r     <= RANK_WIDTH'(1);
                r_total <= '0;
            end
            rtmc_pkg::OP_SIZE: begin
                r_stop <= r_start + r_n + COUNT_WIDTH'(inc);
                r_idx  <= r_start;
            end
            rtmc_pkg::OP_JCALC: begin
                r_jump <= low_bit;
                r_diff <= r_stop - r_idx;
            end
            rtmc_pkg::OP_ADV: begin
                r_total <= r_total + 32'd1;
                if (r_jump == '0 || r_jump >= r_diff) begin
                    r_idx <= r_stop;
                end else begin
                    r_idx <= r_idx + r_jump;
                end
            end
            rtmc_pkg::OP_NEXT: begin
                r_start <= r_stop;
                r_r     <= r_r + RANK_WIDTH'(1);
            end
            rtmc_pkg::OP_OUT: begin
                if (out_free) begin
                    r_out_data <= r_total;
                end
            end
            rtmc_pkg::OP_SPECIAL: begin
                if (m_cmp <= CMPW'(1) || r_n == '0) begin
                    r_total <= '0;
                end else begin
                    r_total <= n_dec[31:0];
                end
            end
            default: begin
            end
        endcase
    end

    // checks on the sequencer and the walk
    `RTMC_ASSERT_NEXT(a_accept_to_check, in_fire, r_pc == rtmc_pkg::PC_CHECK)
    `RTMC_ASSERT_NOW(a_adv_in_block, r_pc == rtmc_pkg::PC_ADV, r_idx < r_stop)
    `RTMC_ASSERT_NOW(a_rank_in_range, r_pc == rtmc_pkg::PC_SIZE, r_r < r_rank_count)
    `RTMC_ASSERT_NEXT(a_result_loaded, (r_pc == rtmc_pkg::PC_OUT) && out_free,
                      r_out_valid && (r_pc == rtmc_pkg::PC_IDLE))

endmodule
